FILE: hdl/hsst_pkg.sv
package hsst_pkg;

    localparam int MaxEntries  = 256;
    localparam int HintCount   = 16;
    localparam int SuffixBytes = 8;

    localparam int IdxW   = $clog2(MaxEntries);      // 8
    localparam int CntW   = $clog2(MaxEntries + 1);  // 9
    localparam int HintW  = $clog2(HintCount);
    localparam int HeadW  = 32;
    localparam int SufW   = 8 * SuffixBytes;
    localparam int LenW   = 4;
    localparam int ValW   = 64;
    localparam int EntryW = HeadW + SufW + LenW + ValW;

    localparam logic [2:0] OpInsert  = 3'd0;
    localparam logic [2:0] OpLower   = 3'd1;
    localparam logic [2:0] OpUpper   = 3'd2;
    localparam logic [2:0] OpRebuild = 3'd3;
    localparam logic [2:0] OpClear   = 3'd4;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StBadPos  = 2'd1;
    localparam logic [1:0] StFull    = 2'd2;

    // datapath commands from the controller
    typedef struct packed {
        logic load;       // capture the input item
        logic sp_start;   // start spacing computation
        logic hint_init;  // clear hint scan counters
        logic hint_step;  // examine one hint
        logic range_set;  // form lo/hi from scan result
        logic rd_mid;     // issue read at mid
        logic cmp_mid;    // narrow range with read data
        logic sh_rd;      // read entry k-1 for shift
        logic sh_wr;      // write entry k, decrement k
        logic ins_wr;     // write new entry at pos, bump count
        logic rb_rd;      // read entry for hint i
        logic rb_wr;      // store hint i, advance i
        logic clear;      // zero count and hints
        logic res_load;   // load result register
    } t_cmd;

    typedef struct packed {
        logic sp_done;
        logic hint_done;
        logic search_done;
        logic shift_done;
        logic rb_done;
        logic bad_pos;
        logic full;
        logic cnt_zero;
        logic [2:0] op;
    } t_stat;

endpackage

FILE: hdl/hsst_ram.sv
module hsst_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/hsst_datapath.sv
module hsst_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsst_pkg::t_cmd     i_cmd,
    output hsst_pkg::t_stat    o_stat,
    input  logic [2:0]         i_op,
    input  logic [8:0]         i_pos,
    input  logic [31:0]        i_head,
    input  logic [63:0]        i_suffix,
    input  logic [3:0]         i_len,
    input  logic [63:0]        i_value,
    output logic [1:0]         o_status,
    output logic [8:0]         o_found,
    output logic [8:0]         o_count
);
    import hsst_pkg::*;

    logic [2:0]        r_op;
    logic [CntW-1:0]   r_pos;
    logic [HeadW-1:0]  r_head;
    logic [SufW-1:0]   r_suf;
    logic [LenW-1:0]   r_len;
    logic [ValW-1:0]   r_val;
    logic [CntW-1:0]   r_count;
    logic [HeadW-1:0]  r_hints [HintCount];
    logic [CntW-1:0]   r_sp, r_rem;
    logic [CntW-1:0]   r_lo, r_hi, r_k;
    logic [HintW:0]    r_hi_i, r_hj;
    logic              r_phase;     // 0 counting i, 1 counting j
    logic [HintW:0]    r_rbi;
    logic [1:0]        r_status;
    logic [CntW-1:0]   r_found;

    logic [LenW-1:0]   w_len;
    logic [SufW-1:0]   w_suf;
    logic [CntW-1:0]   w_mid;
    logic [IdxW-1:0]   w_raddr, w_waddr;
    logic              w_we;
    logic [EntryW-1:0] w_wdata, w_rdata;
    logic [HeadW-1:0]  w_rhead;
    logic [SufW-1:0]   w_rsuf;
    logic [LenW-1:0]   w_rlen;
    logic              w_less, w_eq;
    logic [CntW+HintW+1:0] w_prod;

    assign w_len = (i_len > LenW'(SuffixBytes)) ? LenW'(SuffixBytes) : i_len;
    always_comb begin
        w_suf = '0;
        for (int b = 0; b < SuffixBytes; b++) begin
            if (LenW'(b) < w_len) begin
                w_suf[SufW-1-8*b -: 8] = i_suffix[SufW-1-8*b -: 8];
            end
        end
    end

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign {w_rhead, w_rsuf, w_rlen} = w_rdata[EntryW-1:ValW];

    // stored suffix versus target: less / equal, shorter prefix is smaller
    always_comb begin
        logic dec;
        dec = 1'b0;
        w_less = 1'b0;
        w_eq = 1'b0;
        for (int b = 0; b < SuffixBytes; b++) begin
            if (!dec && LenW'(b) < w_rlen && LenW'(b) < r_len) begin
                if (w_rsuf[SufW-1-8*b -: 8] != r_suf[SufW-1-8*b -: 8]) begin
                    dec = 1'b1;
                    w_less = w_rsuf[SufW-1-8*b -: 8] < r_suf[SufW-1-8*b -: 8];
                end
            end
        end
        if (!dec) begin
            w_less = w_rlen < r_len;
            w_eq = w_rlen == r_len;
        end
    end

    always_comb begin
        w_raddr = w_mid[IdxW-1:0];
        if (i_cmd.sh_rd) begin
            w_raddr = IdxW'(r_k - 1'b1);
        end else if (i_cmd.rb_rd) begin
            if (r_sp == '0) w_raddr = IdxW'(r_count - 1'b1);
            else            w_raddr = w_prod[IdxW-1:0];
        end
    end
    assign w_prod = (CntW+HintW+2)'(r_sp) * (CntW+HintW+2)'(r_rbi + 1'b1);

    assign w_we    = i_cmd.sh_wr || i_cmd.ins_wr;
    assign w_waddr = i_cmd.ins_wr ? r_pos[IdxW-1:0] : r_k[IdxW-1:0];
    assign w_wdata = i_cmd.ins_wr ? {r_head, r_suf, r_len, r_val} : w_rdata;

    hsst_ram #(.Width(EntryW), .Depth(MaxEntries)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_pos  <= i_pos;
            r_head <= i_head;
            r_suf  <= w_suf;
            r_len  <= w_len;
            r_val  <= i_value;
            r_k    <= r_count;
        end
        // spacing by repeated subtraction of HintCount+1
        if (i_cmd.sp_start) begin
            r_sp  <= '0;
            r_rem <= r_count;
        end else if (r_rem >= CntW'(HintCount + 1)) begin
            r_sp  <= r_sp + 1'b1;
            r_rem <= r_rem - CntW'(HintCount + 1);
        end
        if (i_cmd.hint_init) begin
            r_hi_i  <= '0;
            r_hj    <= '0;
            r_phase <= 1'b0;
        end else if (i_cmd.hint_step) begin
            if (!r_phase) begin
                if (r_hi_i < (HintW+1)'(HintCount) && r_hints[r_hi_i[HintW-1:0]] < r_head) begin
                    r_hi_i <= r_hi_i + 1'b1;
                    r_hj   <= r_hj + 1'b1;
                end else begin
                    r_phase <= 1'b1;
                end
            end else if (r_hj < (HintW+1)'(HintCount)
                         && r_hints[r_hj[HintW-1:0]] <= r_head) begin
                r_hj <= r_hj + 1'b1;
            end
        end
        if (i_cmd.range_set) begin
            logic [CntW-1:0] lo, hi;
            lo = '0;
            hi = r_count;
            if (r_sp != '0) begin
                if (r_hi_i != '0) lo = CntW'(r_sp * r_hi_i + 1'b1);
                if (r_hj < (HintW+1)'(HintCount)) begin
                    if (CntW'(r_sp * (r_hj + 1'b1) + 1'b1) < r_count
                        && r_sp * (r_hj + 1'b1) + 1'b1 <= (CntW+HintW+2)'(r_count))
                        hi = CntW'(r_sp * (r_hj + 1'b1) + 1'b1);
                end
                if (lo > hi) lo = hi;
            end
            r_lo <= lo;
            r_hi <= hi;
        end
        if (i_cmd.cmp_mid) begin
            if (w_rhead < r_head || (w_rhead == r_head
                && (w_less || (r_op == OpUpper && w_eq)))) begin
                r_lo <= w_mid + 1'b1;
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.sh_wr) begin
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.rb_wr) begin
            r_hints[r_rbi[HintW-1:0]] <= (r_count == '0) ? '0 : w_rhead;
        end
        if (i_cmd.clear) begin
            for (int h = 0; h < HintCount; h++) r_hints[h] <= '0;
        end
        if (i_cmd.res_load) begin
            r_found <= (r_op == OpLower || r_op == OpUpper) ? r_lo : '0;
        end
        if (!i_rst_n) begin
            for (int h = 0; h < HintCount; h++) r_hints[h] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rbi    <= '0;
            r_status <= StOk;
        end else begin
            if (i_cmd.ins_wr) r_count <= r_count + 1'b1;
            if (i_cmd.clear)  r_count <= '0;
            if (i_cmd.load)   r_rbi   <= '0;
            else if (i_cmd.rb_wr) r_rbi <= r_rbi + 1'b1;
            // judge an insert against the count it arrives with
            if (i_cmd.load) begin
                if (i_op == OpInsert && i_pos > r_count)              r_status <= StBadPos;
                else if (i_op == OpInsert && r_count >= CntW'(MaxEntries)) r_status <= StFull;
                else                                                  r_status <= StOk;
            end
        end
    end

    assign o_stat.sp_done     = r_rem < CntW'(HintCount + 1);
    assign o_stat.hint_done   = r_phase && (r_hj >= (HintW+1)'(HintCount)
                                || r_hints[r_hj[HintW-1:0]] > r_head);
    assign o_stat.search_done = r_lo >= r_hi;
    assign o_stat.shift_done  = r_k <= r_pos;
    assign o_stat.rb_done     = r_rbi >= (HintW+1)'(HintCount);
    assign o_stat.bad_pos     = r_pos > r_count;
    assign o_stat.full        = r_count >= CntW'(MaxEntries);
    assign o_stat.cnt_zero    = r_count == '0;
    assign o_stat.op          = r_op;

    assign o_status = r_status;
    assign o_found  = r_found;
    assign o_count  = r_count;
endmodule

FILE: hdl/hsst_ctrl.sv
module hsst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  hsst_pkg::t_stat i_stat,
    output hsst_pkg::t_cmd  o_cmd
);
    import hsst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SPACING, S_HINT, S_RANGE, S_RD, S_CMP,
        S_SHRD, S_SHWR, S_INS, S_RBRD, S_RBWR, S_RES, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = i_in_fire;
        unique case (r_state)
            S_DISPATCH: o_cmd.sp_start = 1'b1;
            S_SPACING:  o_cmd.hint_init = 1'b1;
            S_HINT:     o_cmd.hint_step = 1'b1;
            S_RANGE:    o_cmd.range_set = 1'b1;
            S_RD:       o_cmd.rd_mid = 1'b1;
            S_CMP:      o_cmd.cmp_mid = 1'b1;
            S_SHRD:     o_cmd.sh_rd = 1'b1;
            S_SHWR:     o_cmd.sh_wr = 1'b1;
            S_INS:      o_cmd.ins_wr = 1'b1;
            S_RBRD:     o_cmd.rb_rd = 1'b1;
            S_RBWR:     o_cmd.rb_wr = 1'b1;
            S_RES:      o_cmd.res_load = 1'b1;
            default: ;
        endcase
        if (r_state == S_DISPATCH && i_stat.op == OpClear) o_cmd.clear = 1'b1;
        if (r_state == S_SHWR) o_cmd.sh_rd = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_fire) r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    case (i_stat.op)
                        OpInsert:
                            if (i_stat.bad_pos || i_stat.full) r_state <= S_RES;
                            else r_state <= S_SHRD;
                        OpLower, OpUpper, OpRebuild: r_state <= S_SPACING;
                        default: r_state <= S_RES;
                    endcase
                end
                S_SPACING: if (i_stat.sp_done) begin
                    if (i_stat.op == OpRebuild) r_state <= S_RBRD;
                    else r_state <= S_HINT;
                end
                S_HINT:  if (i_stat.hint_done) r_state <= S_RANGE;
                S_RANGE: r_state <= S_RD;
                S_RD:    r_state <= i_stat.search_done ? S_RES : S_CMP;
                S_CMP:   r_state <= S_RD;
                S_SHRD:  r_state <= i_stat.shift_done ? S_INS : S_SHWR;
                S_SHWR:  r_state <= S_SHRD;
                S_INS:   r_state <= S_RES;
                S_RBRD:  r_state <= i_stat.rb_done ? S_RES : S_RBWR;
                S_RBWR:  r_state <= S_RBRD;
                S_RES: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: if (i_out_ready) begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |=> r_state == S_DISPATCH) else $error("accept not dispatched");
    a_ins_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ins_wr |=> !o_cmd.ins_wr) else $error("double insert");
`endif
endmodule

FILE: hdl/hinted_sorted_slot_table.sv
// Sorted slot table of up to 256 entries (head, suffix, value) with 16 search
// hints. One item in, one result out; items are handled one at a time. A
// search runs the spacing divide, a hint scan and a binary search through the
// registered entry memory, each step a read then a compare. An insert moves
// entries one at a time from the top down to the position, each a read then a
// write; a hint rebuild runs the divide and then reads and stores each hint in
// turn. Clear and errors go straight to the result.
module hinted_sorted_slot_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: op[2:0], pos[11:3], key_head[43:12], key_suffix[107:44],
    //        suffix_len[111:108], entry_value[175:112]
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[1:0], found_index[10:2], entry_count[19:11]
    output logic [23:0]  m_axis_tdata
);
    import hsst_pkg::*;

    t_cmd       w_cmd;
    t_stat      w_stat;
    logic       w_fire;
    logic [1:0] w_status;
    logic [8:0] w_found, w_count;

    assign w_fire = s_axis_tvalid && s_axis_tready;

    hsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_fire),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hsst_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_op    (s_axis_tdata[2:0]),
        .i_pos   (s_axis_tdata[11:3]),
        .i_head  (s_axis_tdata[43:12]),
        .i_suffix(s_axis_tdata[107:44]),
        .i_len   (s_axis_tdata[111:108]),
        .i_value (s_axis_tdata[175:112]),
        .o_status(w_status),
        .o_found (w_found),
        .o_count (w_count)
    );

    assign m_axis_tdata = {4'd0, w_count, w_found, w_status};
endmodule
